// File: sv/osts_pkg.sv
`timescale 1ns / 1ps
package osts_pkg;

  // pixel and histogram sizing
  localparam int PIX_W       = 8;
  localparam int GRAY_LEVELS = 1 << PIX_W;
  localparam int GRAY_MAX    = GRAY_LEVELS - 1;
  localparam int MAX_PIXELS  = 1048576;
  localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W       = CNT_W + PIX_W;

  // score arithmetic widths
  localparam int D2_W    = 2 * PIX_W;
  localparam int T_W     = CNT_W + D2_W;
  localparam int LO_PART = (CNT_W + 1) / 2;
  localparam int HI_PART = CNT_W - LO_PART;
  localparam int SCORE_W = T_W + CNT_W;

  // request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } item_t;

  typedef enum logic [3:0] {
    BK_FILL,
    BK_FLUSH,
    BK_READ,
    BK_ACC,
    BK_CHK,
    BK_DIV1,
    BK_DIV2,
    BK_MUL1,
    BK_MUL2,
    BK_MUL3,
    BK_MUL4,
    BK_SCORE,
    BK_NEXT,
    BK_DONE
  } back_state_t;

endpackage

// File: sv/osts_front.sv
`timescale 1ns / 1ps
module osts_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_pixel,
  input  logic                 in_last_pixel,
  output osts_pkg::item_t      q_item,
  output logic                 q_valid,
  input  logic                 q_pop
);
  import osts_pkg::*;

  item_t             buf_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  // request handshake and queue status
  assign busy    = (cnt_r == QCNT_W'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = buf_r[rd_ptr_r];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // tag each request with its end-of-image flag
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r].pixel <= in_pixel;
      buf_r[wr_ptr_r].last  <= in_last_pixel;
    end
  end

endmodule

// File: sv/osts_div.sv
`timescale 1ns / 1ps
module osts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [osts_pkg::SUM_W-1:0] dividend,
  input  logic [osts_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [osts_pkg::PIX_W-1:0] quot
);
  import osts_pkg::*;

  localparam int STEP_W = $clog2(PIX_W);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  dsh_r;
  logic [PIX_W-1:0]  q_r;
  logic              ge;

  // the quotient is a mean gray level, so it always fits in PIX_W bits
  assign ge   = (rem_r >= dsh_r);
  assign done = done_r;
  assign quot = q_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(PIX_W - 1);
      end else if (run_r) begin
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= SUM_W'({divisor, {(PIX_W - 1){1'b0}}});
      q_r   <= '0;
    end else if (run_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[PIX_W-2:0], ge};
    end
  end

endmodule

// File: sv/osts_back.sv
`timescale 1ns / 1ps
module osts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  osts_pkg::item_t      q_item,
  input  logic                 q_valid,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [7:0]           out_threshold
);
  import osts_pkg::*;

  back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       hist_mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] valid_r;

  logic [CNT_W-1:0] total_r;
  logic [SUM_W-1:0] sum_r;
  logic [PIX_W-1:0] min_r;
  logic [PIX_W-1:0] max_r;

  logic             a_vld_r;
  logic [PIX_W-1:0] a_px_r;
  logic [CNT_W-1:0] rd_data_r;
  logic             rd_valid_r;
  logic             wr_vld_r;
  logic [PIX_W-1:0] wr_addr_r;
  logic [CNT_W-1:0] wr_data_r;

  logic [PIX_W-1:0]   k_r;
  logic [CNT_W-1:0]   lo_cnt_r;
  logic [SUM_W-1:0]   lo_sum_r;
  logic [PIX_W-1:0]   m1_r;
  logic [PIX_W-1:0]   diff_r;
  logic [D2_W-1:0]    d2_r;
  logic [T_W-1:0]     t_r;
  logic [T_W+LO_PART-1:0] pl_r;
  logic [T_W+HI_PART-1:0] ph_r;
  logic [SCORE_W-1:0] best_r;
  logic [PIX_W-1:0]   best_k_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_thr_r;

  logic             counted;
  logic [PIX_W-1:0] rd_addr;
  logic [CNT_W-1:0] hist_h;
  logic [CNT_W-1:0] hi_cnt;
  logic [SUM_W-1:0] hi_sum;
  logic [CNT_W-1:0] b_cnt;
  logic [CNT_W-1:0] b_new;
  logic [SUM_W-1:0] hk;
  logic [SCORE_W-1:0] score;

  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic             div_done;
  logic [PIX_W-1:0] div_quot;

  osts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // datapath terms
  assign q_pop   = q_valid && (state_r == BK_FILL);
  assign counted = (total_r < CNT_W'(MAX_PIXELS));
  assign rd_addr = (state_r == BK_READ) ? k_r : q_item.pixel;
  assign hist_h  = rd_valid_r ? rd_data_r : '0;
  assign hi_cnt  = total_r - lo_cnt_r;
  assign hi_sum  = sum_r - lo_sum_r;
  assign hk      = hist_h * k_r;
  assign score   = SCORE_W'(pl_r) + {ph_r, {LO_PART{1'b0}}};

  // bin update forwards the write of the previous cycle
  assign b_cnt = (wr_vld_r && (wr_addr_r == a_px_r)) ? wr_data_r : hist_h;
  assign b_new = b_cnt + 1'b1;

  assign out_valid     = out_valid_r;
  assign out_threshold = out_thr_r;

  // sequencer: next state and divider requests
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = lo_sum_r;
    div_divisor  = lo_cnt_r;
    case (state_r)
      BK_FILL:  if (q_pop && q_item.last) state_nxt = BK_FLUSH;
      BK_FLUSH: state_nxt = BK_READ;
      BK_READ:  state_nxt = (k_r < max_r) ? BK_ACC : BK_DONE;
      BK_ACC:   state_nxt = BK_CHK;
      BK_CHK: begin
        if ((lo_cnt_r == '0) || (hi_cnt == '0)) begin
          state_nxt = BK_NEXT;
        end else begin
          div_start = 1'b1;
          state_nxt = BK_DIV1;
        end
      end
      BK_DIV1: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = hi_sum;
          div_divisor  = hi_cnt;
          state_nxt    = BK_DIV2;
        end
      end
      BK_DIV2:  if (div_done) state_nxt = BK_MUL1;
      BK_MUL1:  state_nxt = BK_MUL2;
      BK_MUL2:  state_nxt = BK_MUL3;
      BK_MUL3:  state_nxt = BK_MUL4;
      BK_MUL4:  state_nxt = BK_SCORE;
      BK_SCORE: state_nxt = BK_NEXT;
      BK_NEXT:  state_nxt = BK_READ;
      BK_DONE:  state_nxt = BK_FILL;
      default:  state_nxt = BK_FILL;
    endcase
  end

  // control state and image statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL;
      a_vld_r     <= 1'b0;
      wr_vld_r    <= 1'b0;
      valid_r     <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      min_r       <= PIX_W'(GRAY_MAX);
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == BK_DONE);
      a_vld_r     <= q_pop && counted;
      wr_vld_r    <= a_vld_r;
      if (a_vld_r) valid_r[a_px_r] <= 1'b1;
      if (q_pop && counted) begin
        total_r <= total_r + 1'b1;
        sum_r   <= sum_r + SUM_W'(q_item.pixel);
        if (q_item.pixel < min_r) min_r <= q_item.pixel;
        if (q_item.pixel > max_r) max_r <= q_item.pixel;
      end
      // back to the empty image after the result
      if (state_r == BK_DONE) begin
        valid_r <= '0;
        total_r <= '0;
        sum_r   <= '0;
        min_r   <= PIX_W'(GRAY_MAX);
        max_r   <= '0;
      end
    end
  end

  // histogram memory, one read and one write port
  always_ff @(posedge clk) begin
    a_px_r     <= q_item.pixel;
    rd_data_r  <= hist_mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
    if (a_vld_r) begin
      hist_mem[a_px_r] <= b_new;
      wr_addr_r        <= a_px_r;
      wr_data_r        <= b_new;
    end
  end

  // candidate sweep datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_FLUSH: begin
        k_r      <= min_r;
        lo_cnt_r <= '0;
        lo_sum_r <= '0;
        best_r   <= '0;
        best_k_r <= min_r;
      end
      BK_ACC: begin
        lo_cnt_r <= lo_cnt_r + hist_h;
        lo_sum_r <= lo_sum_r + hk;
      end
      BK_DIV1:  if (div_done) m1_r <= div_quot;
      BK_DIV2: begin
        if (div_done) diff_r <= (m1_r > div_quot) ? (m1_r - div_quot) : (div_quot - m1_r);
      end
      BK_MUL1:  d2_r <= diff_r * diff_r;
      BK_MUL2:  t_r <= lo_cnt_r * d2_r;
      BK_MUL3:  pl_r <= t_r * hi_cnt[LO_PART-1:0];
      BK_MUL4:  ph_r <= t_r * hi_cnt[CNT_W-1:LO_PART];
      BK_SCORE: begin
        if (score > best_r) begin
          best_r   <= score;
          best_k_r <= k_r;
        end
      end
      BK_NEXT:  k_r <= k_r + 1'b1;
      BK_DONE:  out_thr_r <= best_k_r;
      default: ;
    endcase
  end

endmodule

// File: sv/otsu_threshold_select_unit.sv
`timescale 1ns / 1ps
// channel   ports                           handshake
// input     in_pixel, in_last_pixel         start high while busy low
// result    out_threshold                   out_valid strobe, one cycle
//
// pixels enter one per cycle while busy is low, through a four-entry
// queue into the histogram. after the last pixel the sweep visits each
// candidate level (min..max-1); a candidate with both classes non-empty
// uses the shared 8-step divider twice, one with an empty class skips it.
// the result strobes one cycle; statistics clear on the edge that raises it.
// reset is synchronous; busy rises only while the queue is full; the
// receiver cannot stall results.
module otsu_threshold_select_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_pixel,
  input  logic       in_last_pixel,
  output logic       out_valid,
  output logic [7:0] out_threshold
);
  import osts_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  osts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pixel      (in_pixel),
    .in_last_pixel (in_last_pixel),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  osts_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_threshold (out_threshold)
  );

endmodule

// File: sv/osts_chk.sv
`timescale 1ns / 1ps
module osts_chk (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);

  // no result straight after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // queue empties on reset
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // a result strobe is never held high
  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

endmodule

bind otsu_threshold_select_unit osts_chk u_chk (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import osts_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_FROM = 1200;
  localparam int NO_EXP = -1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_pixel = '0;
  logic       in_last_pixel = 1'b0;
  logic       out_valid;
  logic [7:0] out_threshold;

  otsu_threshold_select_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel(in_pixel), .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_threshold(out_threshold)
  );

  always #2 clk = ~clk;

  // predictor state for the image being collected
  int unsigned      gray_hist [GRAY_LEVELS];
  int unsigned      lo_gray, hi_gray, counted;
  logic [7:0]       pending_thresh [$];
  int               mismatches = 0;
  int unsigned      cycles = 0;

  function automatic void clear_image();
    foreach (gray_hist[i]) gray_hist[i] = 0;
    lo_gray = GRAY_MAX;
    hi_gray = 0;
    counted = 0;
  endfunction

  // integer form of the between-class variance sweep, with truncated class means
  function automatic logic [7:0] otsu_pick();
    longint unsigned all_n, all_s, lo_n, lo_s, hi_n, hi_s, m1, m2, d, score, best;
    int unsigned     best_k;
    all_n = 0; all_s = 0; lo_n = 0; lo_s = 0; best = 0;
    best_k = lo_gray;
    for (int unsigned i = lo_gray; i <= hi_gray && i < GRAY_LEVELS; i++) begin
      all_n += gray_hist[i];
      all_s += longint'(gray_hist[i]) * i;
    end
    for (int unsigned k = lo_gray; k < hi_gray; k++) begin
      lo_n += gray_hist[k];
      lo_s += longint'(gray_hist[k]) * k;
      hi_n = all_n - lo_n;
      hi_s = all_s - lo_s;
      if (lo_n != 0 && hi_n != 0) begin
        m1 = lo_s / lo_n;
        m2 = hi_s / hi_n;
        d = (m1 > m2) ? m1 - m2 : m2 - m1;
        score = lo_n * hi_n * d * d;
        if (score > best) begin
          best = score;
          best_k = k;
        end
      end
    end
    return best_k[7:0];
  endfunction

  // returns the predicted threshold, or NO_EXP when the pixel gives none
  function automatic int count_pixel(logic [7:0] px, logic last);
    int res;
    res = NO_EXP;
    if (counted < MAX_PIXELS) begin
      gray_hist[px]++;
      counted++;
      if (px < lo_gray) lo_gray = px;
      if (px > hi_gray) hi_gray = px;
    end
    if (last) begin
      res = otsu_pick();
      clear_image();
    end
    return res;
  endfunction

  // one request, held until accepted
  task automatic send_pixel(logic [7:0] px, logic last, int typed);
    int pred;
    start <= 1'b1;
    in_pixel <= px;
    in_last_pixel <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = count_pixel(px, last);
    if (typed != NO_EXP && typed != pred) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row: typed %0d, predicted %0d", typed, pred);
    end
    if (pred != NO_EXP) pending_thresh.push_back(pred[7:0]);
  endtask

  task automatic idle_burst(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_thresh.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected threshold %0d", out_threshold);
      end else begin
        if (out_threshold !== pending_thresh[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("threshold: expected %0d, actual %0d",
                     pending_thresh[0], out_threshold);
        end
        void'(pending_thresh.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] px;
    logic       last;
    int         typed;
  } stim_row_t;

  // directed requests: extremes, single levels, two-level and multi-level images
  stim_row_t directed [22] = '{
    '{8'd0,   1'b1, 0},
    '{8'd255, 1'b1, 255},
    '{8'd0,   1'b0, NO_EXP}, '{8'd255, 1'b1, 0},
    '{8'd128, 1'b0, NO_EXP}, '{8'd128, 1'b0, NO_EXP}, '{8'd128, 1'b1, 128},
    '{8'd255, 1'b0, NO_EXP}, '{8'd255, 1'b0, NO_EXP},
    '{8'd0,   1'b0, NO_EXP}, '{8'd0,   1'b1, 0},
    '{8'd7,   1'b0, NO_EXP}, '{8'd8,   1'b1, 7},
    '{8'd10,  1'b0, NO_EXP}, '{8'd12,  1'b0, NO_EXP}, '{8'd200, 1'b0, NO_EXP},
    '{8'd201, 1'b0, NO_EXP}, '{8'd90,  1'b1, NO_EXP},
    '{8'd85,  1'b0, NO_EXP}, '{8'd170, 1'b0, NO_EXP}, '{8'd15,  1'b0, NO_EXP},
    '{8'd240, 1'b1, NO_EXP}
  };

  initial begin
    int sent, len, base, span, top;
    logic [7:0] px;
    clear_image();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_pixel(directed[i].px, directed[i].last, directed[i].typed);
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 6));
    end

    // random images, mostly narrow gray ranges to keep the sweep short
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(1, 24);
      base = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0:       span = 255;
        1:       span = 0;
        default: span = $urandom_range(1, 15);
      endcase
      top = (base + span > 255) ? 255 : base + span;
      for (int j = 0; j < len; j++) begin
        px = 8'($urandom_range(base, top));
        send_pixel(px, j == len - 1, NO_EXP);
        sent++;
        if (sent < CALM_FROM && $urandom_range(0, 4) == 0)
          idle_burst($urandom_range(1, 6));
      end
    end
    start <= 1'b0;

    while (pending_thresh.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: otsu_threshold_select_unit.f
sv/osts_pkg.sv
sv/osts_front.sv
sv/osts_div.sv
sv/osts_back.sv
sv/otsu_threshold_select_unit.sv
sv/osts_chk.sv
bench/tb_top.sv
